// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the Huffman engine datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every clock edge outside reset
`define HCD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define HCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/hcd_pkg.sv
// ----------------------------------------------------------------------------
// hcd_pkg
// Types, sizes and command codes of the Huffman engine.
// ----------------------------------------------------------------------------
package hcd_pkg;

  localparam int MAX_SYMBOLS = 32;
  localparam int NODE_SLOTS  = 2 * MAX_SYMBOLS - 1;
  localparam int NW          = $clog2(NODE_SLOTS);      // node index width
  localparam int LW          = $clog2(MAX_SYMBOLS);     // list index width
  localparam int CW          = $clog2(MAX_SYMBOLS + 1); // list count width
  localparam int WW          = 13;                      // weight width
  localparam logic [WW-1:0] WEIGHT_MAX = 13'd8191;
  localparam int CODE_W      = 31;
  localparam int LEN_W       = 5;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_DECODE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TABLE  = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_DECODE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_TREE   = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LEAF,
    OP_SCAN,
    OP_INS,
    OP_MERGE,
    OP_FINISH,
    OP_TR_INIT,
    OP_FETCH,
    OP_DESCEND,
    OP_LEAF_STEP,
    OP_ENC_OUT,
    OP_EMIT_OVF,
    OP_EMIT_NOTREE,
    OP_FETCH_DEC,
    OP_DEC_CHILD,
    OP_DEC_LEAF,
    OP_DEC_MOVE
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_LD_CLR,
    S_LD_CHK,
    S_LD_SCAN,
    S_BLD_CHK,
    S_BLD_SCAN,
    S_TR_INIT,
    S_TR_FETCH,
    S_TR_EVAL,
    S_ENC_OUT,
    S_OVF,
    S_NOTREE,
    S_DEC_FETCH,
    S_DEC_EVAL,
    S_DEC_FETCH2,
    S_DEC_EVAL2
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   idle;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic last;
    logic tree_ready;
    logic list_full;
    logic pair_left;
    logic scan_done;
    logic node_leaf;
    logic stack_empty;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic          leaf;
    logic [7:0]    sym;
    logic [NW-1:0] left;
    logic [NW-1:0] right;
  } node_t;

endpackage

// File: hdl/hcd_ctrl.sv
// ----------------------------------------------------------------------------
// hcd_ctrl
// Sequencer for load, tree build, table walk, encode, decode and clear.
// ----------------------------------------------------------------------------
module hcd_ctrl
  import hcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_LOAD:   state_nxt = stat.tree_ready ? S_LD_CLR : S_LD_CHK;
          CMD_ENCODE: state_nxt = stat.tree_ready ? S_TR_INIT : S_NOTREE;
          CMD_DECODE: state_nxt = stat.tree_ready ? S_DEC_FETCH : S_NOTREE;
          CMD_CLEAR:  state_nxt = S_IDLE;
        endcase
      end
      S_LD_CLR: state_nxt = S_LD_CHK;
      S_LD_CHK: begin
        if (stat.list_full) state_nxt = stat.last ? S_BLD_CHK : S_OVF;
        else                state_nxt = S_LD_SCAN;
      end
      S_LD_SCAN: begin
        if (stat.scan_done) state_nxt = stat.last ? S_BLD_CHK : S_IDLE;
      end
      S_BLD_CHK:  state_nxt = stat.pair_left ? S_BLD_SCAN : S_TR_INIT;
      S_BLD_SCAN: begin
        if (stat.scan_done) state_nxt = S_BLD_CHK;
      end
      S_TR_INIT:  state_nxt = S_TR_FETCH;
      S_TR_FETCH: state_nxt = S_TR_EVAL;
      S_TR_EVAL: begin
        if (!stat.node_leaf) begin
          state_nxt = S_TR_FETCH;
        end else if (stat.out_free || stat.cmd != CMD_LOAD) begin
          if (!stat.stack_empty)         state_nxt = S_TR_FETCH;
          else if (stat.cmd == CMD_LOAD) state_nxt = S_IDLE;
          else                           state_nxt = S_ENC_OUT;
        end
      end
      S_ENC_OUT, S_OVF, S_NOTREE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_DEC_FETCH: state_nxt = S_DEC_EVAL;
      S_DEC_EVAL: begin
        if (!stat.node_leaf)    state_nxt = S_DEC_FETCH2;
        else if (stat.out_free) state_nxt = S_IDLE;
      end
      S_DEC_FETCH2: state_nxt = S_DEC_EVAL2;
      S_DEC_EVAL2: begin
        if (!stat.node_leaf || stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.idle = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: cmd.op = OP_NONE;
      S_DISPATCH: begin
        if (stat.cmd == CMD_CLEAR) cmd.op = OP_CLEAR;
      end
      S_LD_CLR:   cmd.op = OP_CLEAR;
      S_LD_CHK:   cmd.op = OP_LEAF;
      S_LD_SCAN, S_BLD_SCAN: cmd.op = stat.scan_done ? OP_INS : OP_SCAN;
      S_BLD_CHK:  cmd.op = stat.pair_left ? OP_MERGE : OP_FINISH;
      S_TR_INIT:  cmd.op = OP_TR_INIT;
      S_TR_FETCH, S_DEC_FETCH2: cmd.op = OP_FETCH;
      S_TR_EVAL: begin
        if (!stat.node_leaf) cmd.op = OP_DESCEND;
        else if (stat.out_free || stat.cmd != CMD_LOAD) cmd.op = OP_LEAF_STEP;
      end
      S_ENC_OUT: begin
        if (stat.out_free) cmd.op = OP_ENC_OUT;
      end
      S_OVF: begin
        if (stat.out_free) cmd.op = OP_EMIT_OVF;
      end
      S_NOTREE: begin
        if (stat.out_free) cmd.op = OP_EMIT_NOTREE;
      end
      S_DEC_FETCH: cmd.op = OP_FETCH_DEC;
      S_DEC_EVAL: begin
        if (!stat.node_leaf)    cmd.op = OP_DEC_CHILD;
        else if (stat.out_free) cmd.op = OP_DEC_LEAF;
      end
      S_DEC_EVAL2: begin
        if (!stat.node_leaf)    cmd.op = OP_DEC_MOVE;
        else if (stat.out_free) cmd.op = OP_DEC_LEAF;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: hdl/hcd_dp.sv
// ----------------------------------------------------------------------------
// hcd_dp
// Sorted list, node memory, walk stack and result register.
// ----------------------------------------------------------------------------
module hcd_dp
  import hcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_symbol,
  input  logic [7:0]        in_weight,
  input  logic              in_bit,
  input  logic              in_last,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_symbol,
  output logic [CODE_W-1:0] out_code,
  output logic [LEN_W-1:0]  out_length,
  output logic [1:0]        out_status,
  output logic              out_last,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat
);

`include "assert_macros.svh"

  typedef struct packed {
    logic [NW-1:0]     node;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } stk_t;

  // latched item
  cmd_t       cmd_r;
  logic [7:0] sym_r;
  logic [7:0] wt_r;
  logic       bit_r;
  logic       last_r;

  // sorted list
  logic [WW-1:0] list_w_r [MAX_SYMBOLS];
  logic [NW-1:0] list_n_r [MAX_SYMBOLS];
  logic [CW-1:0] list_count_r;
  logic [CW-1:0] p_r;
  logic [WW-1:0] ins_w_r;
  logic [NW-1:0] ins_n_r;
  logic          drop_r;

  // tree
  node_t         mem [NODE_SLOTS];
  node_t         rdata_r;
  logic [NW-1:0] rd_addr;
  logic [NW-1:0] node_count_r;
  logic [NW-1:0] root_r;
  logic          tree_ready_r;
  logic [NW-1:0] dec_pos_r;

  // walk
  stk_t              stk_r [MAX_SYMBOLS];
  logic [CW-1:0]     sp_r;
  logic [NW-1:0]     cur_r;
  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  len_r;
  logic              found_r;
  logic [CODE_W-1:0] fcode_r;
  logic [LEN_W-1:0]  flen_r;
  stk_t              top_ent;

  // result register
  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [7:0]        out_symbol_r;
  logic [CODE_W-1:0] out_code_r;
  logic [LEN_W-1:0]  out_length_r;
  logic [1:0]        out_status_r;
  logic              out_last_r;

  logic          take;
  logic          out_free;
  logic          emit;
  logic [WW:0]   pair_sum;
  logic [WW-1:0] merge_w;
  logic          list_full;
  logic          table_mode;

  assign take       = in_valid && cmd.idle;
  assign out_free   = !out_valid_r || out_ready;
  assign list_full  = (list_count_r == CW'(MAX_SYMBOLS));
  assign table_mode = (cmd_r == CMD_LOAD);
  assign pair_sum   = {1'b0, list_w_r[0]} + {1'b0, list_w_r[1]};
  assign merge_w    = pair_sum[WW] ? WEIGHT_MAX : pair_sum[WW-1:0];
  assign top_ent    = stk_r[LW'(sp_r - CW'(1))];
  assign rd_addr    = (cmd.op == OP_FETCH_DEC) ? dec_pos_r : cur_r;

  assign emit = (cmd.op == OP_EMIT_OVF) || (cmd.op == OP_EMIT_NOTREE) ||
                (cmd.op == OP_ENC_OUT) || (cmd.op == OP_DEC_LEAF) ||
                ((cmd.op == OP_LEAF_STEP) && table_mode);

  always_comb begin
    stat.cmd         = cmd_r;
    stat.last        = last_r;
    stat.tree_ready  = tree_ready_r;
    stat.list_full   = list_full;
    stat.pair_left   = (list_count_r >= CW'(2));
    stat.scan_done   = (p_r == list_count_r) || (list_w_r[p_r[LW-1:0]] >= ins_w_r);
    stat.node_leaf   = rdata_r.leaf;
    stat.stack_empty = (sp_r == '0);
    stat.out_free    = out_free;
  end

  // item latch
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r  <= cmd_t'(in_cmd);
      sym_r  <= in_symbol;
      wt_r   <= in_weight;
      bit_r  <= in_bit;
      last_r <= in_last;
    end
  end

  // list storage and insertion registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LEAF: begin
        ins_w_r <= {{(WW-8){1'b0}}, wt_r};
        ins_n_r <= node_count_r;
      end
      OP_MERGE: begin
        ins_w_r <= merge_w;
        ins_n_r <= node_count_r;
        for (int i = 0; i < MAX_SYMBOLS - 2; i++) begin
          list_w_r[i] <= list_w_r[i+2];
          list_n_r[i] <= list_n_r[i+2];
        end
      end
      OP_INS: begin
        for (int i = 1; i < MAX_SYMBOLS; i++) begin
          if (CW'(i) > p_r && CW'(i) <= list_count_r) begin
            list_w_r[i] <= list_w_r[i-1];
            list_n_r[i] <= list_n_r[i-1];
          end
        end
        list_w_r[p_r[LW-1:0]] <= ins_w_r;
        list_n_r[p_r[LW-1:0]] <= ins_n_r;
      end
      default: ;
    endcase
  end

  // node memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LEAF && !list_full) begin
      mem[node_count_r] <= '{leaf: 1'b1, sym: sym_r, left: '0, right: '0};
    end else if (cmd.op == OP_MERGE) begin
      mem[node_count_r] <= '{leaf: 1'b0, sym: 8'd0, left: list_n_r[0], right: list_n_r[1]};
    end
    rdata_r <= mem[rd_addr];
  end

  // walk stack
  always_ff @(posedge clk) begin
    if (cmd.op == OP_DESCEND) begin
      stk_r[sp_r[LW-1:0]] <= '{node: rdata_r.right, code: {code_r[CODE_W-2:0], 1'b1},
                               len: len_r + LEN_W'(1)};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_count_r <= '0;
      node_count_r <= '0;
      root_r       <= '0;
      tree_ready_r <= 1'b0;
      dec_pos_r    <= '0;
      sp_r         <= '0;
      p_r          <= '0;
      drop_r       <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CLEAR: begin
          list_count_r <= '0;
          node_count_r <= '0;
          root_r       <= '0;
          tree_ready_r <= 1'b0;
          dec_pos_r    <= '0;
        end
        OP_LEAF: begin
          drop_r <= list_full;
          p_r    <= '0;
          if (!list_full) node_count_r <= node_count_r + NW'(1);
        end
        OP_SCAN: p_r <= p_r + CW'(1);
        OP_INS:  list_count_r <= list_count_r + CW'(1);
        OP_MERGE: begin
          list_count_r <= list_count_r - CW'(2);
          node_count_r <= node_count_r + NW'(1);
          p_r          <= '0;
        end
        OP_FINISH: begin
          root_r       <= list_n_r[0];
          dec_pos_r    <= list_n_r[0];
          tree_ready_r <= 1'b1;
        end
        OP_TR_INIT: begin
          sp_r    <= '0;
          found_r <= 1'b0;
        end
        OP_DESCEND: sp_r <= sp_r + CW'(1);
        OP_LEAF_STEP: begin
          if (!table_mode && rdata_r.sym == sym_r) found_r <= 1'b1;
          if (sp_r != '0) sp_r <= sp_r - CW'(1);
        end
        OP_DEC_LEAF: dec_pos_r <= root_r;
        OP_DEC_MOVE: dec_pos_r <= cur_r;
        default: ;
      endcase
    end
  end

  // walk position and found code
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_TR_INIT: begin
        cur_r  <= root_r;
        code_r <= '0;
        len_r  <= '0;
      end
      OP_DESCEND: begin
        cur_r  <= rdata_r.left;
        code_r <= {code_r[CODE_W-2:0], 1'b0};
        len_r  <= len_r + LEN_W'(1);
      end
      OP_LEAF_STEP: begin
        if (!table_mode && rdata_r.sym == sym_r) begin
          fcode_r <= code_r;
          flen_r  <= len_r;
        end
        if (sp_r != '0) begin
          cur_r  <= top_ent.node;
          code_r <= top_ent.code;
          len_r  <= top_ent.len;
        end
      end
      OP_DEC_CHILD: cur_r <= bit_r ? rdata_r.right : rdata_r.left;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_code_r   <= '0;
      out_length_r <= '0;
      out_last_r   <= 1'b0;
      out_status_r <= ST_OK;
      out_symbol_r <= sym_r;
      unique case (cmd.op)
        OP_EMIT_OVF: begin
          out_kind_r   <= KIND_TABLE;
          out_status_r <= ST_NO_TREE;
        end
        OP_EMIT_NOTREE: begin
          out_status_r <= ST_NO_TREE;
          if (cmd_r == CMD_ENCODE) begin
            out_kind_r <= KIND_ENCODE;
          end else begin
            out_kind_r   <= KIND_DECODE;
            out_symbol_r <= 8'd0;
          end
        end
        OP_ENC_OUT: begin
          out_kind_r <= KIND_ENCODE;
          if (found_r) begin
            out_code_r   <= fcode_r;
            out_length_r <= flen_r;
          end else begin
            out_status_r <= ST_NOT_FOUND;
          end
        end
        OP_DEC_LEAF: begin
          out_kind_r   <= KIND_DECODE;
          out_symbol_r <= rdata_r.sym;
        end
        default: begin
          out_kind_r   <= KIND_TABLE;
          out_symbol_r <= rdata_r.sym;
          out_code_r   <= code_r;
          out_length_r <= len_r;
          out_status_r <= drop_r ? ST_NO_TREE : ST_OK;
          out_last_r   <= (sp_r == '0);
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_symbol = out_symbol_r;
  assign out_code   = out_code_r;
  assign out_length = out_length_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  `HCD_ASSERT_ALWAYS(a_list_bound, list_count_r <= CW'(MAX_SYMBOLS), "list count beyond capacity")
  `HCD_ASSERT_IMPL(a_emit_free, emit, out_free, "result written over a pending beat")
  `HCD_ASSERT_IMPL(a_ins_room, cmd.op == OP_INS, !list_full, "insert into a full list")

endmodule

// File: hdl/huffman_tree_codec.sv
// ----------------------------------------------------------------------------
// huffman_tree_codec
// Huffman engine: sorted load, tree build, code table, encode, decode.
// ----------------------------------------------------------------------------
// Use: one command beat on the in_ channel (valid/ready), zero or more result
// beats on the out_ channel (valid/ready).
//   load   : walks the sorted list, one entry per cycle, then inserts the
//            entry. A load with in_last builds the tree (per merge: the
//            merge, then the list walk and insert) and streams the code
//            table, fetching and evaluating each tree node visited.
//   encode : walks the whole tree node by node, then one answer beat.
//   decode : one or two node reads per bit, through the registered read port
//            of the node memory.
//   clear  : no result.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register while the next command is taken. When the receiver
// stalls, the sequencer waits at its next result until the register frees.
// Reset (rst_n low, synchronous) empties list and tree and drops any pending
// result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module huffman_tree_codec
  import hcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_symbol,
  input  logic [7:0]        in_weight,
  input  logic              in_bit,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_symbol,
  output logic [CODE_W-1:0] out_code,
  output logic [LEN_W-1:0]  out_length,
  output logic [1:0]        out_status,
  output logic              out_last
);

  dp_cmd_t  cmd;   // sequencer -> datapath
  dp_stat_t stat;  // datapath -> sequencer

  // input beat accepted only in idle
  assign in_ready = cmd.idle;

  hcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  hcd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_cmd     (in_cmd),
    .in_symbol  (in_symbol),
    .in_weight  (in_weight),
    .in_bit     (in_bit),
    .in_last    (in_last),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_kind   (out_kind),
    .out_symbol (out_symbol),
    .out_code   (out_code),
    .out_length (out_length),
    .out_status (out_status),
    .out_last   (out_last),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// File: test/huffman_tree_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_codec_tb
// Self-checking bench for the Huffman engine. A short table of directed beats
// (no-tree answers, single-symbol tree, ties, duplicates, rebuild) runs first,
// then random dictionaries: a list overflow, a degenerate chain with 31-bit
// codes and many small trees, each followed by encodes and decode bit streams.
// A behavioral model of the list, node table and decoder predicts the beats
// not typed in a row; both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module huffman_tree_codec_tb;
  import hcd_pkg::*;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    status_t           st;
    logic              last;
  } beat_t;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] sym;
    logic [7:0] w;
    logic       b;
    logic       last;
    logic       typed;  // row carries its own expected beat
    beat_t      want;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_cmd;
  logic [7:0]        in_symbol;
  logic [7:0]        in_weight;
  logic              in_bit;
  logic              in_last;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_kind;
  logic [7:0]        out_symbol;
  logic [CODE_W-1:0] out_code;
  logic [LEN_W-1:0]  out_length;
  logic [1:0]        out_status;
  logic              out_last;

  huffman_tree_codec dut (.*);

  // ---------------------------------------------------------------------------
  // Shadow copy of the engine state
  // ---------------------------------------------------------------------------
  int unsigned sh_list_w   [MAX_SYMBOLS];
  int unsigned sh_list_n   [MAX_SYMBOLS];
  int unsigned sh_list_cnt;
  int unsigned sh_left     [NODE_SLOTS];
  int unsigned sh_right    [NODE_SLOTS];
  logic [7:0]  sh_sym      [NODE_SLOTS];
  bit          sh_leaf     [NODE_SLOTS];
  int unsigned sh_node_cnt;
  int unsigned sh_root;
  bit          sh_tree;
  int unsigned sh_dec_pos;

  beat_t       awaited_q[$];  // result beats still owed by the engine
  int          n_errors = 0;
  bit          calm     = 0;  // tail of the run: no idling anywhere
  logic [7:0]  dict_syms[$];  // symbols of the current dictionary

  function automatic beat_t mk(kind_t k, logic [7:0] s, logic [63:0] c, int unsigned l,
                               status_t st, logic last);
    beat_t r;
    r.kind = k; r.sym = s; r.code = c[CODE_W-1:0]; r.len = l[LEN_W-1:0];
    r.st = st; r.last = last;
    return r;
  endfunction

  function automatic void wipe();
    for (int i = 0; i < NODE_SLOTS; i++) begin
      sh_left[i] = 0; sh_right[i] = 0; sh_sym[i] = 0; sh_leaf[i] = 0;
    end
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      sh_list_w[i] = 0; sh_list_n[i] = 0;
    end
    sh_list_cnt = 0; sh_node_cnt = 0; sh_root = 0; sh_tree = 0; sh_dec_pos = 0;
  endfunction

  // sorted insert: ahead of the first entry of equal or greater weight
  function automatic void list_put(int unsigned w, int unsigned n);
    int unsigned p;
    p = 0;
    if (sh_list_cnt >= MAX_SYMBOLS) return;
    while (p < sh_list_cnt && sh_list_w[p] < w) p++;
    for (int i = sh_list_cnt; i > p; i--) begin
      sh_list_w[i] = sh_list_w[i-1]; sh_list_n[i] = sh_list_n[i-1];
    end
    sh_list_w[p] = w; sh_list_n[p] = n;
    sh_list_cnt++;
  endfunction

  function automatic void merge_all();
    int unsigned n, w;
    while (sh_list_cnt >= 2 && sh_node_cnt < NODE_SLOTS) begin
      n = sh_node_cnt++;
      w = sh_list_w[0] + sh_list_w[1];
      if (w > WEIGHT_MAX) w = WEIGHT_MAX;
      sh_left[n] = sh_list_n[0]; sh_right[n] = sh_list_n[1];
      sh_sym[n] = 0; sh_leaf[n] = 0;
      for (int i = 2; i < sh_list_cnt; i++) begin
        sh_list_w[i-2] = sh_list_w[i]; sh_list_n[i-2] = sh_list_n[i];
      end
      sh_list_cnt -= 2;
      list_put(w, n);
    end
    sh_root = (sh_list_n[0] < NODE_SLOTS) ? sh_list_n[0] : 0;
    sh_dec_pos = sh_root;
    sh_tree = 1;
  endfunction

  // Depth-first walk, left branch first. Table mode collects every leaf (max 32),
  // search mode keeps the last leaf holding 'target' (rightmost wins).
  function automatic void walk_tree(bit table_mode, status_t st, logic [7:0] target,
                                    ref beat_t res[$]);
    int unsigned stk_n[NODE_SLOTS+1];
    logic [63:0] stk_c[NODE_SLOTS+1];
    int unsigned stk_l[NODE_SLOTS+1];
    int unsigned sp, x, l, emitted;
    logic [63:0] c, hit_c;
    int unsigned hit_l;
    bit hit;
    stk_n[0] = sh_root; stk_c[0] = 0; stk_l[0] = 0; sp = 1;
    emitted = 0; hit = 0; hit_c = 0; hit_l = 0;
    while (sp > 0 && !(table_mode && emitted >= 32)) begin
      sp--;
      x = stk_n[sp]; c = stk_c[sp]; l = stk_l[sp];
      if (x >= NODE_SLOTS) continue;
      if (sh_leaf[x]) begin
        if (table_mode) begin
          res.push_back(mk(KIND_TABLE, sh_sym[x], c, l, st, 1'b0));
          emitted++;
        end else if (sh_sym[x] == target) begin
          hit = 1; hit_c = c; hit_l = l;
        end
      end else if (sp + 2 <= NODE_SLOTS + 1) begin
        stk_n[sp] = sh_right[x]; stk_c[sp] = (c << 1) | 64'd1; stk_l[sp] = l + 1; sp++;
        stk_n[sp] = sh_left[x];  stk_c[sp] = c << 1;           stk_l[sp] = l + 1; sp++;
      end
    end
    if (table_mode) begin
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
    end else if (hit)
      res.push_back(mk(KIND_ENCODE, target, hit_c, hit_l, ST_OK, 1'b0));
    else
      res.push_back(mk(KIND_ENCODE, target, 0, 0, ST_NOT_FOUND, 1'b0));
  endfunction

  // Advances the shadow state by one command beat and returns its result beats.
  function automatic void huff_predict(cmd_t cmd, logic [7:0] s, logic [7:0] w, logic b,
                                       logic last, ref beat_t res[$]);
    bit dropped;
    int unsigned n, nxt, pos;
    res.delete();
    case (cmd)
      CMD_LOAD: begin
        if (sh_tree) wipe();
        dropped = (sh_list_cnt >= MAX_SYMBOLS) || (sh_node_cnt >= NODE_SLOTS);
        if (!dropped) begin
          n = sh_node_cnt++;
          sh_left[n] = 0; sh_right[n] = 0; sh_sym[n] = s; sh_leaf[n] = 1;
          list_put(w, n);
        end
        if (!last) begin
          if (dropped) res.push_back(mk(KIND_TABLE, s, 0, 0, ST_NO_TREE, 1'b0));
        end else if (sh_list_cnt == 0)
          res.push_back(mk(KIND_TABLE, 8'h00, 0, 0, ST_NO_TREE, 1'b1));
        else begin
          merge_all();
          walk_tree(1'b1, dropped ? ST_NO_TREE : ST_OK, 8'h00, res);
        end
      end
      CMD_ENCODE: begin
        if (!sh_tree) res.push_back(mk(KIND_ENCODE, s, 0, 0, ST_NO_TREE, 1'b0));
        else walk_tree(1'b0, ST_OK, s, res);
      end
      CMD_DECODE: begin
        pos = sh_dec_pos;
        if (!sh_tree || pos >= NODE_SLOTS)
          res.push_back(mk(KIND_DECODE, 8'h00, 0, 0, ST_NO_TREE, 1'b0));
        else if (sh_leaf[pos]) begin
          // single-symbol tree: every bit yields the root symbol
          res.push_back(mk(KIND_DECODE, sh_sym[pos], 0, 0, ST_OK, 1'b0));
          sh_dec_pos = sh_root;
        end else begin
          nxt = b ? sh_right[pos] : sh_left[pos];
          if (nxt >= NODE_SLOTS) sh_dec_pos = sh_root;
          else if (sh_leaf[nxt]) begin
            res.push_back(mk(KIND_DECODE, sh_sym[nxt], 0, 0, ST_OK, 1'b0));
            sh_dec_pos = sh_root;
          end else sh_dec_pos = nxt;
        end
      end
      default: wipe();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall bursts, then check every accepted beat. Sampled on the
  // falling edge, so the values seen are those the next rising edge takes.
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      if (calm || $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  always @(negedge clk) begin
    beat_t w;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_q.size() == 0) begin
        $error("result beat with nothing awaited: kind %0d sym %h", out_kind, out_symbol);
        n_errors++;
      end else begin
        w = awaited_q.pop_front();
        if (out_kind !== w.kind) begin
          $error("kind: expected %0d, got %0d", w.kind, out_kind); n_errors++;
        end
        if (out_symbol !== w.sym) begin
          $error("symbol: expected %h, got %h", w.sym, out_symbol); n_errors++;
        end
        if (out_code !== w.code) begin
          $error("code: expected %h, got %h", w.code, out_code); n_errors++;
        end
        if (out_length !== w.len) begin
          $error("length: expected %0d, got %0d", w.len, out_length); n_errors++;
        end
        if (out_status !== w.st) begin
          $error("status: expected %0d, got %0d", w.st, out_status); n_errors++;
        end
        if (out_last !== w.last) begin
          $error("last: expected %b, got %b", w.last, out_last); n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  int n_sent = 0;

  // One command beat: optional gap, hold valid until taken, then book results.
  task automatic send_cmd(cmd_t cmd, logic [7:0] s, logic [7:0] w, logic b, logic last,
                          bit typed = 0, beat_t want = '0);
    beat_t res[$];
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_symbol <= s;
    in_weight <= w;
    in_bit    <= b;
    in_last   <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);  // beat taken here
    huff_predict(cmd, s, w, b, last, res);
    if (typed) awaited_q.push_back(want);
    else foreach (res[i]) awaited_q.push_back(res[i]);
    n_sent++;
  endtask

  // n loads, last one flagged; weight style 0 random, 1 all zero (deep chain)
  task automatic load_dict(int n, int style);
    logic [7:0] s;
    dict_syms.delete();
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(0, 255);
      dict_syms.push_back(s);
      send_cmd(CMD_LOAD, s, (style == 1) ? 8'h00 : 8'($urandom_range(0, 255)), 1'($urandom),
               i == n - 1);
    end
  endtask

  row_t dir_rows[$];

  initial begin
    row_t r;
    int n;
    in_valid = 1'b0; in_cmd = CMD_LOAD; in_symbol = 8'h00; in_weight = 8'h00;
    in_bit = 1'b0; in_last = 1'b0;
    rst_n = 1'b0;
    wipe();

    // directed rows; typed answers where they are obvious
    dir_rows = '{
      '{CMD_DECODE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
        mk(KIND_DECODE, 8'h00, 0, 0, ST_NO_TREE, 1'b0)},
      '{CMD_ENCODE, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1,
        mk(KIND_ENCODE, 8'hFF, 0, 0, ST_NO_TREE, 1'b0)},
      '{CMD_LOAD,   8'hA5, 8'hFF, 1'b0, 1'b1, 1'b1,
        mk(KIND_TABLE, 8'hA5, 0, 0, ST_OK, 1'b1)},
      '{CMD_ENCODE, 8'hA5, 8'h00, 1'b0, 1'b0, 1'b1,
        mk(KIND_ENCODE, 8'hA5, 0, 0, ST_OK, 1'b0)},
      '{CMD_DECODE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
        mk(KIND_DECODE, 8'hA5, 0, 0, ST_OK, 1'b0)},
      '{CMD_DECODE, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1,
        mk(KIND_DECODE, 8'hA5, 0, 0, ST_OK, 1'b0)},
      '{CMD_ENCODE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
        mk(KIND_ENCODE, 8'h00, 0, 0, ST_NOT_FOUND, 1'b0)},
      '{CMD_CLEAR,  8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, '0},
      '{CMD_ENCODE, 8'h5A, 8'h00, 1'b0, 1'b0, 1'b1,
        mk(KIND_ENCODE, 8'h5A, 0, 0, ST_NO_TREE, 1'b0)},
      // ties, zero and full weights, a symbol loaded twice
      '{CMD_LOAD,   8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_LOAD,   8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_LOAD,   8'h3C, 8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_LOAD,   8'h3C, 8'h80, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_LOAD,   8'h81, 8'h80, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_ENCODE, 8'h3C, 8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_ENCODE, 8'h81, 8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_ENCODE, 8'h7E, 8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_DECODE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_DECODE, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{CMD_DECODE, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{CMD_DECODE, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{CMD_DECODE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0},
      // load after a build starts a fresh dictionary
      '{CMD_LOAD,   8'h11, 8'h01, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_DECODE, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_cmd(r.cmd, r.sym, r.w, r.b, r.last, r.typed, r.want);
    end

    // random dictionaries; the first is oversized, the second a zero-weight chain
    for (int ph = 0; n_sent < 220; ph++) begin
      if (n_sent >= 185) calm = 1;
      if (ph == 0) begin
        // two drops without last, then one with last: table flagged
        load_dict(35, 0);
      end else if (ph == 1) load_dict(MAX_SYMBOLS, 1);
      else if ($urandom_range(0, 5) == 0) begin
        // noise: any command, any field
        repeat ($urandom_range(1, 4))
          send_cmd(cmd_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 1'($urandom),
                   1'($urandom));
        continue;
      end else load_dict($urandom_range(2, 8), 0);

      repeat ($urandom_range(1, 4)) begin
        n = dict_syms.size();
        send_cmd(CMD_ENCODE,
                 ($urandom_range(0, 4) == 0) ? 8'($urandom) : dict_syms[$urandom_range(0, n-1)],
                 8'($urandom), 1'($urandom), 1'($urandom));
      end
      repeat ($urandom_range(4, 20))
        send_cmd(CMD_DECODE, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0);
      if ($urandom_range(0, 3) == 0) send_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom), 1'b0, 1'b0);
    end
    in_valid <= 1'b0;

    // drain: everything awaited must arrive, then a quiet tail
    n = 0;
    while (awaited_q.size() != 0) begin
      @(posedge clk);
      n++;
      if (n > 500_000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
    repeat (200) @(posedge clk);
    if (n_errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/hcd_pkg.sv
hdl/hcd_ctrl.sv
hdl/hcd_dp.sv
hdl/huffman_tree_codec.sv
test/huffman_tree_codec_tb.sv
